@@ hdl/pidci_pkg.sv @@
// Shared constants, types and helper functions of the conditional-integration PID block.
package pidci_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int DT_W       = 16;
    localparam int GAIN_W     = 32;
    localparam int DRIVE_W    = 16;
    localparam int CFG_IDX_W  = 8;

    localparam int ERR_W      = DATA_WIDTH + 1;
    localparam int INT_W      = 48;
    localparam int RATE_W     = ERR_W + 10;

    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 48;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int MUL_STEPS  = MUL_B_W;

    localparam int QUO_W      = 58;
    localparam int DIV_W      = 16;
    localparam int DIV_STEPS  = QUO_W;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);

    localparam int IMAG_W     = QUO_W + 1;
    localparam int TERM_W     = 62;

    localparam int unsigned SECOND_MS = 1000;

    localparam logic signed [TERM_W-1:0] ONE_Q16 = TERM_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_F = CFG_IDX_W'(3);

    typedef struct packed {
        logic load;
        logic step;
    } seq_ctrl_t;

    function automatic logic [MUL_A_W-1:0] gain_mag(input logic signed [GAIN_W-1:0] g);
        return g[GAIN_W-1] ? MUL_A_W'(-g) : MUL_A_W'(g);
    endfunction

    function automatic logic signed [TERM_W-1:0] signed_term(input logic [IMAG_W-1:0] m,
                                                             input logic neg);
        logic signed [TERM_W-1:0] v;
        v = signed'(TERM_W'(m));
        return neg ? -v : v;
    endfunction

    // Clamp to plus or minus one in Q.16, then round to Q2.14 with ties going upwards.
    function automatic logic signed [DRIVE_W-1:0] drive_from_total(
        input logic signed [TERM_W-1:0] t);
        logic signed [TERM_W-1:0] c;
        if (t > ONE_Q16) begin
            c = ONE_Q16;
        end else if (t < -ONE_Q16) begin
            c = -ONE_Q16;
        end else begin
            c = t;
        end
        c = c + TERM_W'(2);
        return DRIVE_W'(c >>> 2);
    endfunction

endpackage

@@ hdl/pidci_mul_serial.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle while step is asserted.
module pidci_mul_serial (
    input  logic                           aclk,
    input  pidci_pkg::seq_ctrl_t           ctrl,
    input  logic [pidci_pkg::MUL_A_W-1:0]  a,
    input  logic [pidci_pkg::MUL_B_W-1:0]  b,
    output logic [pidci_pkg::PROD_W-1:0]   product
);
    import pidci_pkg::*;

    logic [PROD_W-1:0]  mcand_reg, mcand_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [MUL_B_W-1:0] mplier_reg, mplier_next;

    // Once the multiplier has shifted out to zero, further steps leave the product alone.
    always_comb begin
        mcand_next  = mcand_reg;
        acc_next    = acc_reg;
        mplier_next = mplier_reg;
        if (ctrl.load) begin
            mcand_next  = PROD_W'(a);
            acc_next    = '0;
            mplier_next = b;
        end else if (ctrl.step) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg  <= mcand_next;
        acc_reg    <= acc_next;
        mplier_reg <= mplier_next;
    end

    assign product = acc_reg;

endmodule

@@ hdl/pidci_div_serial.sv @@
// Restoring divider that produces one quotient bit per cycle while step is asserted.
module pidci_div_serial (
    input  logic                          aclk,
    input  pidci_pkg::seq_ctrl_t          ctrl,
    input  logic [pidci_pkg::QUO_W-1:0]   dividend,
    input  logic [pidci_pkg::DIV_W-1:0]   rem_init,
    input  logic [pidci_pkg::DIV_W-1:0]   divisor,
    output logic [pidci_pkg::QUO_W-1:0]   quotient
);
    import pidci_pkg::*;

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [DIV_W:0]   shifted_rem;

    assign shifted_rem = {rem_reg, quo_reg[QUO_W-1]};

    // The remainder stays below the divisor, so the shifted value fits one extra bit.
    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (ctrl.load) begin
            rem_next = rem_init;
            quo_next = dividend;
        end else if (ctrl.step) begin
            if (shifted_rem >= {1'b0, divisor}) begin
                rem_next = DIV_W'(shifted_rem - {1'b0, divisor});
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_next = shifted_rem[DIV_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;

endmodule

@@ hdl/pid_conditional_integration_top.sv @@
// PID controller with conditional integration: sequencer, state and serial arithmetic units.
//
// Channels: s_* carries one control step (setpoint, measurement, elapsed milliseconds),
// m_* returns one Q2.14 drive value per step, and cfg_* writes the four Q16.16 gains
// (index 0 proportional, 1 integral, 2 derivative, 3 feedforward; other indexes are ignored).
// The gain port is always ready; gains are meant to be written while no item is in flight.
// Each item runs through bit-serial multipliers and restoring dividers. When the
// anti-windup test holds the integral, one pass forms the result; when the integral
// moves, the integral term is formed a second time with the new sum.
// A new item is taken as soon as the sequencer is idle, even while the previous drive
// value still waits in the output register. If the receiver stalls, a finished result
// waits inside the block until the output register is free.
// Synchronous reset clears the gains, the stored measurement and the integral, and
// empties the output register.
module pid_conditional_integration_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pidci_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pidci_pkg::GAIN_W-1:0]         cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [pidci_pkg::DATA_WIDTH-1:0] s_setpoint,
    input  logic signed [pidci_pkg::DATA_WIDTH-1:0] s_measurement,
    input  logic [pidci_pkg::DT_W-1:0]           s_elapsed_ms,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pidci_pkg::DRIVE_W-1:0] m_drive
);
    import pidci_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_LOAD  = 9'b000000010,
        ST_MUL   = 9'b000000100,
        ST_DIVLD = 9'b000001000,
        ST_DIV   = 9'b000010000,
        ST_SUM   = 9'b000100000,
        ST_TRIAL = 9'b001000000,
        ST_FINAL = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    localparam logic signed [INT_W+1:0] INT_HI = signed'((INT_W+2)'({(INT_W-1){1'b1}}));
    localparam logic signed [INT_W+1:0] INT_LO = ~INT_HI;
    localparam logic [IMAG_W-1:0] I_CAP = {1'b1, {QUO_W{1'b0}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(16384);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic pass_reg, pass_next;
    logic m_valid_reg, m_valid_next;

    logic signed [GAIN_W-1:0] gain_p_reg, gain_p_next;
    logic signed [GAIN_W-1:0] gain_i_reg, gain_i_next;
    logic signed [GAIN_W-1:0] gain_d_reg, gain_d_next;
    logic signed [GAIN_W-1:0] gain_f_reg, gain_f_next;
    logic signed [DATA_WIDTH-1:0] prev_meas_reg, prev_meas_next;
    logic signed [INT_W-1:0] integ_reg, integ_next;

    logic signed [DATA_WIDTH-1:0] sp_reg, sp_next;
    logic signed [DATA_WIDTH-1:0] pv_reg, pv_next;
    logic [DT_W-1:0] dt_reg, dt_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic diff_neg_reg, diff_neg_next;
    logic cap_i_reg, cap_i_next;
    logic signed [TERM_W-1:0] pdf_reg, pdf_next;
    logic signed [TERM_W-1:0] i_term_reg, i_term_next;
    logic signed [DRIVE_W-1:0] drive_res_reg, drive_res_next;
    logic signed [DRIVE_W-1:0] m_drive_reg, m_drive_next;

    logic signed [ERR_W-1:0] err_w, diff_w;
    logic [ERR_W-1:0] err_mag, diff_mag;
    logic [DATA_WIDTH-1:0] sp_mag;
    logic [RATE_W-1:0] rate_mag;
    logic [INT_W-1:0] integ_mag;

    seq_ctrl_t mul_ctrl, mul_i_ctrl, div_ctrl;
    logic [PROD_W-1:0] prod_p, prod_f, prod_d, prod_i, prod_e;
    logic [QUO_W-1:0] quo_d, quo_i;

    logic [IMAG_W-1:0] i_mag, d_mag;
    logic signed [TERM_W-1:0] trial_w;
    logic big_w, skip_w;
    logic signed [INT_W+1:0] errdt_w, int_sum_w;
    logic signed [INT_W-1:0] int_sat_w;

    assign err_w  = ERR_W'(sp_reg) - ERR_W'(pv_reg);
    assign diff_w = ERR_W'(pv_reg) - ERR_W'(prev_meas_reg);
    assign err_mag  = err_w[ERR_W-1] ? ERR_W'(-err_w) : ERR_W'(err_w);
    assign diff_mag = diff_w[ERR_W-1] ? ERR_W'(-diff_w) : ERR_W'(diff_w);
    assign sp_mag   = sp_reg[DATA_WIDTH-1] ? DATA_WIDTH'(-sp_reg) : DATA_WIDTH'(sp_reg);
    assign integ_mag = integ_reg[INT_W-1] ? INT_W'(-integ_reg) : INT_W'(integ_reg);

    // Times one thousand as 1024 - 16 - 8.
    assign rate_mag = (RATE_W'(diff_mag) << 10) - (RATE_W'(diff_mag) << 4)
                    - (RATE_W'(diff_mag) << 3);

    // The second pass only recomputes the integral term; the other products stay put.
    assign mul_ctrl.load   = (state_reg == ST_LOAD) && !pass_reg;
    assign mul_ctrl.step   = (state_reg == ST_MUL);
    assign mul_i_ctrl.load = (state_reg == ST_LOAD);
    assign mul_i_ctrl.step = (state_reg == ST_MUL);
    assign div_ctrl.load   = (state_reg == ST_DIVLD);
    assign div_ctrl.step   = (state_reg == ST_DIV);

    pidci_mul_serial u_mul_p (
        .aclk    (aclk),
        .ctrl    (mul_ctrl),
        .a       (gain_mag(gain_p_reg)),
        .b       (MUL_B_W'(err_mag)),
        .product (prod_p)
    );

    pidci_mul_serial u_mul_f (
        .aclk    (aclk),
        .ctrl    (mul_ctrl),
        .a       (gain_mag(gain_f_reg)),
        .b       (MUL_B_W'(sp_mag)),
        .product (prod_f)
    );

    pidci_mul_serial u_mul_d (
        .aclk    (aclk),
        .ctrl    (mul_ctrl),
        .a       (gain_mag(gain_d_reg)),
        .b       (MUL_B_W'(rate_mag)),
        .product (prod_d)
    );

    pidci_mul_serial u_mul_e (
        .aclk    (aclk),
        .ctrl    (mul_ctrl),
        .a       (MUL_A_W'(dt_reg)),
        .b       (MUL_B_W'(err_mag)),
        .product (prod_e)
    );

    pidci_mul_serial u_mul_i (
        .aclk    (aclk),
        .ctrl    (mul_i_ctrl),
        .a       (gain_mag(gain_i_reg)),
        .b       (MUL_B_W'(integ_mag)),
        .product (prod_i)
    );

    pidci_div_serial u_div_d (
        .aclk     (aclk),
        .ctrl     (div_ctrl),
        .dividend (prod_d[QUO_W-1:0]),
        .rem_init ('0),
        .divisor  (dt_reg),
        .quotient (quo_d)
    );

    // Below the cap the bits above the quotient width are already less than one thousand.
    pidci_div_serial u_div_i (
        .aclk     (aclk),
        .ctrl     (div_ctrl),
        .dividend (prod_i[QUO_W-1:0]),
        .rem_init (DIV_W'(prod_i[PROD_W-1:QUO_W])),
        .divisor  (DIV_W'(SECOND_MS)),
        .quotient (quo_i)
    );

    assign i_mag = cap_i_reg ? I_CAP : {1'b0, quo_i};
    assign d_mag = (dt_reg == '0) ? '0 : {1'b0, quo_d};

    assign trial_w = pdf_reg + i_term_reg;
    assign big_w   = (trial_w >= ONE_Q16) || (trial_w <= -ONE_Q16);
    assign skip_w  = big_w && (err_reg[ERR_W-1] == integ_reg[INT_W-1]);

    assign errdt_w = err_reg[ERR_W-1]
                   ? -signed'((INT_W+2)'(prod_e[ERR_W+DT_W-1:0]))
                   :  signed'((INT_W+2)'(prod_e[ERR_W+DT_W-1:0]));
    assign int_sum_w = (INT_W+2)'(integ_reg) + errdt_w;

    always_comb begin
        if (int_sum_w > INT_HI) begin
            int_sat_w = INT_W'(INT_HI);
        end else if (int_sum_w < INT_LO) begin
            int_sat_w = INT_W'(INT_LO);
        end else begin
            int_sat_w = INT_W'(int_sum_w);
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pass_next      = pass_reg;
        m_valid_next   = m_valid_reg;
        gain_p_next    = gain_p_reg;
        gain_i_next    = gain_i_reg;
        gain_d_next    = gain_d_reg;
        gain_f_next    = gain_f_reg;
        prev_meas_next = prev_meas_reg;
        integ_next     = integ_reg;
        sp_next        = sp_reg;
        pv_next        = pv_reg;
        dt_next        = dt_reg;
        err_next       = err_reg;
        diff_neg_next  = diff_neg_reg;
        cap_i_next     = cap_i_reg;
        pdf_next       = pdf_reg;
        i_term_next    = i_term_reg;
        drive_res_next = drive_res_reg;
        m_drive_next   = m_drive_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GAIN_P: gain_p_next = signed'(cfg_data);
                CFG_GAIN_I: gain_i_next = signed'(cfg_data);
                CFG_GAIN_D: gain_d_next = signed'(cfg_data);
                CFG_GAIN_F: gain_f_next = signed'(cfg_data);
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sp_next    = s_setpoint;
                    pv_next    = s_measurement;
                    dt_next    = s_elapsed_ms;
                    pass_next  = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (!pass_reg) begin
                    err_next       = err_w;
                    diff_neg_next  = diff_w[ERR_W-1];
                    prev_meas_next = pv_reg;
                end
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                    state_next = ST_DIVLD;
                end
            end
            ST_DIVLD: begin
                cap_i_next = prod_i[PROD_W-1:QUO_W] >= (PROD_W-QUO_W)'(SECOND_MS);
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                i_term_next = signed_term(i_mag, gain_i_reg[GAIN_W-1] ^ integ_reg[INT_W-1]);
                pdf_next = signed_term(prod_p[IMAG_W-1:0],
                                       gain_p_reg[GAIN_W-1] ^ err_reg[ERR_W-1])
                         + signed_term(prod_f[IMAG_W-1:0],
                                       gain_f_reg[GAIN_W-1] ^ sp_reg[DATA_WIDTH-1])
                         - signed_term(d_mag, gain_d_reg[GAIN_W-1] ^ diff_neg_reg);
                state_next = pass_reg ? ST_FINAL : ST_TRIAL;
            end
            ST_TRIAL: begin
                if (skip_w) begin
                    drive_res_next = drive_from_total(trial_w);
                    state_next     = ST_DONE;
                end else begin
                    integ_next = int_sat_w;
                    pass_next  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_FINAL: begin
                drive_res_next = drive_from_total(trial_w);
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_drive_next = drive_res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pass_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            gain_f_reg    <= '0;
            prev_meas_reg <= '0;
            integ_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pass_reg      <= pass_next;
            m_valid_reg   <= m_valid_next;
            gain_p_reg    <= gain_p_next;
            gain_i_reg    <= gain_i_next;
            gain_d_reg    <= gain_d_next;
            gain_f_reg    <= gain_f_next;
            prev_meas_reg <= prev_meas_next;
            integ_reg     <= integ_next;
        end
    end

    always_ff @(posedge aclk) begin
        sp_reg        <= sp_next;
        pv_reg        <= pv_next;
        dt_reg        <= dt_next;
        err_reg       <= err_next;
        diff_neg_reg  <= diff_neg_next;
        cap_i_reg     <= cap_i_next;
        pdf_reg       <= pdf_next;
        i_term_reg    <= i_term_next;
        drive_res_reg <= drive_res_next;
        m_drive_reg   <= m_drive_next;
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_drive   = m_drive_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_LOAD))
        else $error("accepted item did not start the sequencer");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result presented without a finished computation");

    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_drive <= DRIVE_MAX) && (m_drive >= -DRIVE_MAX)))
        else $error("drive outside plus or minus one");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg < CNT_W'(DIV_STEPS)))
        else $error("divider step count overran");
`endif

endmodule
